FILE: sv/pll_pkg.sv
// ----------------------------------------------------------------------------
// Positional linked list package
// Operation codes, status codes and controller states shared by the list
// engine modules.
// ----------------------------------------------------------------------------
package pll_pkg;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 7;
    localparam int DIN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_GET    = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WALK_REQ,
        S_WALK_WAIT,
        S_READ_REQ,
        S_READ_WAIT,
        S_UPD_A,
        S_UPD_B,
        S_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic walk_start;
        logic rd_cur;
        logic walk_step;
        logic do_insert;
        logic do_delete;
        logic do_get;
        logic do_clear;
        logic upd_b;
        logic set_fail_range;
        logic set_fail_full;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic pos_bad;
        logic full;
        logic walk_done;
        logic need_walk;
    } t_sts;

endpackage

FILE: sv/pll_if.sv
// ----------------------------------------------------------------------------
// Positional linked list channel
// Valid and ready handshake carrying one payload of parameterized width W.
// ----------------------------------------------------------------------------
interface pll_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/pll_ctrl.sv
// ----------------------------------------------------------------------------
// Positional linked list controller
// Sequences range check, list walk, node read and link updates per request.
// ----------------------------------------------------------------------------
module pll_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_busy,
    output logic            o_out_load,
    input  pll_pkg::t_func  i_func,
    input  pll_pkg::t_sts   i_sts,
    output pll_pkg::t_cmd   o_cmd
);

    pll_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pll_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pll_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pll_pkg::S_CHECK;
                end
            end
            pll_pkg::S_CHECK: begin
                if (i_func == pll_pkg::FN_CLEAR) begin
                    n_state = pll_pkg::S_UPD_A;
                end else if (i_sts.pos_bad || (i_func == pll_pkg::FN_INSERT && i_sts.full)) begin
                    n_state = pll_pkg::S_DONE;
                end else if (!i_sts.need_walk) begin
                    n_state = pll_pkg::S_UPD_A;
                end else begin
                    n_state = pll_pkg::S_WALK_REQ;
                end
            end
            pll_pkg::S_WALK_REQ: begin
                if (i_sts.walk_done) begin
                    n_state = pll_pkg::S_READ_REQ;
                end else begin
                    n_state = pll_pkg::S_WALK_WAIT;
                end
            end
            pll_pkg::S_WALK_WAIT: n_state = pll_pkg::S_WALK_REQ;
            pll_pkg::S_READ_REQ:  n_state = pll_pkg::S_READ_WAIT;
            pll_pkg::S_READ_WAIT: n_state = pll_pkg::S_UPD_A;
            pll_pkg::S_UPD_A:     n_state = pll_pkg::S_UPD_B;
            pll_pkg::S_UPD_B:     n_state = pll_pkg::S_DONE;
            pll_pkg::S_DONE: begin
                if (!i_out_busy) begin
                    n_state = pll_pkg::S_IDLE;
                end
            end
            default: n_state = pll_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            pll_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = i_in_valid;
            end
            pll_pkg::S_CHECK: begin
                o_cmd.walk_start     = 1'b1;
                o_cmd.set_fail_range = i_sts.pos_bad && i_func != pll_pkg::FN_CLEAR;
                o_cmd.set_fail_full  = !i_sts.pos_bad && i_sts.full
                                       && i_func == pll_pkg::FN_INSERT;
            end
            pll_pkg::S_WALK_REQ: begin
                o_cmd.rd_cur = 1'b1;
            end
            pll_pkg::S_WALK_WAIT: begin
                o_cmd.walk_step = 1'b1;
            end
            pll_pkg::S_READ_REQ: begin
                o_cmd.rd_cur = 1'b1;
            end
            pll_pkg::S_UPD_A: begin
                o_cmd.do_insert = i_func == pll_pkg::FN_INSERT;
                o_cmd.do_delete = i_func == pll_pkg::FN_DELETE;
                o_cmd.do_get    = i_func == pll_pkg::FN_GET;
                o_cmd.do_clear  = i_func == pll_pkg::FN_CLEAR;
            end
            pll_pkg::S_UPD_B: begin
                o_cmd.upd_b = 1'b1;
            end
            pll_pkg::S_DONE: begin
                o_out_load = !i_out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == pll_pkg::S_IDLE)
        else $error("load outside idle");
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.do_insert, o_cmd.do_delete, o_cmd.do_get, o_cmd.do_clear}))
        else $error("several updates at once");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> r_state == pll_pkg::S_DONE)
        else $error("result loaded outside done");

endmodule

FILE: sv/pll_dp.sv
// ----------------------------------------------------------------------------
// Positional linked list datapath
// Node store memories, free map, head and count registers, and walk pointer.
// ----------------------------------------------------------------------------
module pll_dp #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pll_pkg::t_cmd               i_cmd,
    output pll_pkg::t_sts               o_sts,
    input  logic [pll_pkg::FUNC_W-1:0]  i_func,
    input  logic [pll_pkg::POS_W-1:0]   i_position,
    input  logic [pll_pkg::DIN_W-1:0]   i_data_in,
    output pll_pkg::t_func              o_func,
    output logic [pll_pkg::DIN_W-1:0]   o_data_out,
    output logic [pll_pkg::STATUS_W-1:0] o_status,
    output logic [pll_pkg::COUNT_W-1:0] o_count,
    output logic                        o_empty_res
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    logic [DATA_WIDTH-1:0] m_rec  [CAPACITY];
    logic [IW-1:0]         m_next [CAPACITY];
    logic [IW-1:0]         m_prev [CAPACITY];

    logic [CAPACITY-1:0]       r_free;
    logic [IW-1:0]             r_head;
    logic [IW-1:0]             r_count;
    pll_pkg::t_func            r_func;
    logic [pll_pkg::POS_W-1:0] r_pos;
    logic [DATA_WIDTH-1:0]     r_din;
    logic [IW-1:0]             r_cur;
    logic [pll_pkg::POS_W-1:0] r_steps;
    logic [IW-1:0]             r_rd_next;
    logic [IW-1:0]             r_rd_prev;
    logic [DATA_WIDTH-1:0]     r_rd_rec;
    logic [AW-1:0]             r_new;
    logic [IW-1:0]             r_fix;
    logic [pll_pkg::STATUS_W-1:0] r_status;
    logic [DATA_WIDTH-1:0]     r_dout;

    logic [AW-1:0]            w_low;
    logic                     w_any;
    logic [pll_pkg::POS_W:0]  w_lim;
    logic [pll_pkg::POS_W-1:0] w_target;
    logic                     w_we_next, w_we_prev, w_we_rec;
    logic [AW-1:0]            w_a_next, w_a_prev;
    logic [IW-1:0]            w_d_next, w_d_prev;

    // Lowest free node by priority search.
    always_comb begin
        w_low = '0;
        w_any = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_low = AW'(i);
                w_any = 1'b1;
            end
        end
    end

    // Insert stops at position-1, delete and get at position.
    assign w_target = (r_func == pll_pkg::FN_INSERT) ? r_pos - 1'b1 : r_pos;
    assign w_lim = (r_func == pll_pkg::FN_INSERT) ? ({1'b0, 7'(r_count)} + 1'b1)
                                                   : {1'b0, 7'(r_count)};

    assign o_sts.pos_bad   = r_pos == '0 || {1'b0, r_pos} > w_lim;
    assign o_sts.full      = !w_any;
    assign o_sts.need_walk = !(r_func == pll_pkg::FN_INSERT && r_pos == 7'd1);
    assign o_sts.walk_done = r_steps == w_target;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= pll_pkg::t_func'(i_func);
            r_pos  <= i_position;
            r_din  <= i_data_in[DATA_WIDTH-1:0];
        end
        if (i_cmd.walk_start) begin
            r_cur    <= r_head;
            r_steps  <= 7'd1;
            r_new    <= w_low;
            r_status <= i_cmd.set_fail_range ? pll_pkg::ST_RANGE
                      : i_cmd.set_fail_full ? pll_pkg::ST_FULL : pll_pkg::ST_OK;
            r_dout   <= '0;
        end
        if (i_cmd.rd_cur) begin
            r_rd_next <= m_next[r_cur[AW-1:0]];
            r_rd_prev <= m_prev[r_cur[AW-1:0]];
            r_rd_rec  <= m_rec[r_cur[AW-1:0]];
        end
        if (i_cmd.walk_step) begin
            r_cur   <= r_rd_next;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.do_insert) begin
            r_fix <= o_sts.need_walk ? r_rd_next : r_head;
        end
        if (i_cmd.do_delete || i_cmd.do_get) begin
            r_dout <= r_rd_rec;
        end
        if (i_cmd.do_delete) begin
            r_fix <= r_rd_next;
        end
        if (w_we_rec) begin
            m_rec[r_new] <= r_din;
        end
        if (w_we_next) begin
            m_next[w_a_next] <= w_d_next;
        end
        if (w_we_prev) begin
            m_prev[w_a_prev] <= w_d_prev;
        end
    end

    // Step A writes the new node's links or the unlinked node's neighbors, step B the neighbors of an inserted node.
    always_comb begin
        w_we_rec  = i_cmd.do_insert;
        w_we_next = 1'b0;
        w_we_prev = 1'b0;
        w_a_next  = r_new;
        w_a_prev  = r_new;
        w_d_next  = NIL;
        w_d_prev  = NIL;
        if (i_cmd.do_insert) begin
            w_we_next = 1'b1;
            w_we_prev = 1'b1;
            w_d_next  = o_sts.need_walk ? r_rd_next : r_head;
            w_d_prev  = o_sts.need_walk ? r_cur : NIL;
        end else if (i_cmd.do_delete) begin
            w_we_next = r_rd_prev != NIL;
            w_a_next  = r_rd_prev[AW-1:0];
            w_d_next  = r_rd_next;
            w_we_prev = r_rd_next != NIL;
            w_a_prev  = r_rd_next[AW-1:0];
            w_d_prev  = r_rd_prev;
        end else if (i_cmd.upd_b && r_func == pll_pkg::FN_INSERT
                     && r_status == pll_pkg::ST_OK) begin
            w_we_prev = r_fix != NIL;
            w_a_prev  = r_fix[AW-1:0];
            w_d_prev  = IW'(r_new);
            w_we_next = o_sts.need_walk;
            w_a_next  = r_cur[AW-1:0];
            w_d_next  = IW'(r_new);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '1;
            r_head  <= NIL;
            r_count <= '0;
        end else begin
            if (i_cmd.do_clear) begin
                r_free  <= '1;
                r_head  <= NIL;
                r_count <= '0;
            end
            if (i_cmd.do_insert) begin
                r_free[r_new] <= 1'b0;
                r_count       <= r_count + 1'b1;
                if (!o_sts.need_walk) begin
                    r_head <= IW'(r_new);
                end
            end
            if (i_cmd.do_delete) begin
                r_free[r_cur[AW-1:0]] <= 1'b1;
                r_count               <= r_count - 1'b1;
                if (r_rd_prev == NIL) begin
                    r_head <= r_rd_next;
                end
            end
        end
    end

    assign o_func      = r_func;
    assign o_data_out  = pll_pkg::DIN_W'(r_dout);
    assign o_status    = r_status;
    assign o_count     = pll_pkg::COUNT_W'(r_count);
    assign o_empty_res = r_count == '0;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("count above capacity");
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == NIL))
        else $error("head and count disagree");
    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_free) == CAPACITY - int'(r_count))
        else $error("free map and count disagree");

endmodule

FILE: sv/positional_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Positional linked list engine
// Doubly linked list of records addressed by one-based position.
// ----------------------------------------------------------------------------
// One request is handled at a time. A clear or an insert at position one skips
// the list walk, and a request that fails its range or capacity check goes
// straight to the done state. Other requests walk next links one node at a
// time through the node store read port. The result waits in an output
// register until taken, the controller holds in its done state while that
// register is occupied and not being taken, and the next request is accepted
// once the result is loaded.
module positional_linked_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    pll_if.sink   in_ch,
    pll_if.source out_ch
);

    pll_pkg::t_cmd  w_cmd;
    pll_pkg::t_sts  w_sts;
    pll_pkg::t_func w_func;
    logic           w_out_load;
    logic           w_in_ready;
    logic [pll_pkg::DIN_W-1:0]    w_dout;
    logic [pll_pkg::STATUS_W-1:0] w_status;
    logic [pll_pkg::COUNT_W-1:0]  w_count;
    logic                         w_empty;
    logic r_out_valid;
    logic [pll_pkg::DIN_W+pll_pkg::STATUS_W+pll_pkg::COUNT_W:0] r_out_pl;

    assign in_ch.ready = w_in_ready;

    pll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (w_in_ready),
        .i_out_busy (r_out_valid && !out_ch.ready),
        .o_out_load (w_out_load),
        .i_func     (w_func),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pll_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_func      (in_ch.payload[1:0]),
        .i_position  (in_ch.payload[8:2]),
        .i_data_in   (in_ch.payload[40:9]),
        .o_func      (w_func),
        .o_data_out  (w_dout),
        .o_status    (w_status),
        .o_count     (w_count),
        .o_empty_res (w_empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pl <= {w_empty, w_count, w_status, w_dout};
        end
    end

    assign out_ch.valid   = r_out_valid;
    assign out_ch.payload = r_out_pl;

endmodule

FILE: dv/pll_list_checker.sv
// ----------------------------------------------------------------------------
// Positional linked list checker
// Watches both channels of the list engine, keeps its own copy of the list
// and checks every result against the expected one, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pll_list_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [40:0] i_req_payload,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [41:0] i_rsp_payload,
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic                        empty_res;
        logic [pll_pkg::COUNT_W-1:0] count;
        pll_pkg::t_status            status;
        logic [31:0]                 data_out;
    } t_list_rsp;

    logic [31:0] list_records[$];
    t_list_rsp   rsp_fifo[$];
    int          err_cnt = 0;

    assign o_pending = rsp_fifo.size();
    assign o_errors  = err_cnt;

    function automatic t_list_rsp apply_op(pll_pkg::t_func fn, int pos, logic [31:0] din);
        t_list_rsp r;
        r.data_out = '0;
        r.status   = pll_pkg::ST_OK;
        case (fn)
            pll_pkg::FN_INSERT: begin
                if (pos < 1 || pos > list_records.size() + 1) begin
                    r.status = pll_pkg::ST_RANGE;
                end else if (list_records.size() >= CAPACITY) begin
                    r.status = pll_pkg::ST_FULL;
                end else begin
                    list_records.insert(pos - 1, din);
                end
            end
            pll_pkg::FN_DELETE, pll_pkg::FN_GET: begin
                if (pos < 1 || pos > list_records.size()) begin
                    r.status = pll_pkg::ST_RANGE;
                end else begin
                    r.data_out = list_records[pos-1];
                    if (fn == pll_pkg::FN_DELETE) begin
                        list_records.delete(pos - 1);
                    end
                end
            end
            default: begin
                list_records.delete();
            end
        endcase
        r.count     = pll_pkg::COUNT_W'(list_records.size());
        r.empty_res = (list_records.size() == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_rsp want;
        t_list_rsp got;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                rsp_fifo.push_back(apply_op(pll_pkg::t_func'(i_req_payload[1:0]),
                    int'(i_req_payload[8:2]), i_req_payload[40:9]));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_payload;
                if (rsp_fifo.size() == 0) begin
                    $error("unexpected result %h", i_rsp_payload);
                    err_cnt++;
                end else begin
                    want = rsp_fifo.pop_front();
                    if (got.data_out !== want.data_out) begin
                        $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                        err_cnt++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_cnt++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        err_cnt++;
                    end
                    if (got.empty_res !== want.empty_res) begin
                        $error("empty_res: expected %0d, got %0d", want.empty_res,
                            got.empty_res);
                        err_cnt++;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_positional_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Positional linked list engine testbench
// Drives directed and random list requests through several idle and stall
// phases, including a long output hold-off, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_positional_linked_list_engine;

    localparam int CAPACITY = 64;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    int   list_size;
    int   pending;
    int   errors;

    pll_if #(.W(41)) in_ch ();
    pll_if #(.W(42)) out_ch ();

    positional_linked_list_engine #(.CAPACITY(CAPACITY), .DATA_WIDTH(32)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    pll_list_checker #(.CAPACITY(CAPACITY)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (in_ch.valid),
        .i_req_ready  (in_ch.ready),
        .i_req_payload(in_ch.payload),
        .i_rsp_valid  (out_ch.valid),
        .i_rsp_ready  (out_ch.ready),
        .i_rsp_payload(out_ch.payload),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[positional_linked_list_engine] ERROR");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_request(pll_pkg::t_func fn, int pos, logic [31:0] din);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= {din, 7'(pos), fn};
        do @(posedge i_clk); while (!in_ch.ready);
        case (fn)
            pll_pkg::FN_INSERT: if (pos >= 1 && pos <= list_size + 1 && list_size < CAPACITY)
                list_size++;
            pll_pkg::FN_DELETE: if (pos >= 1 && pos <= list_size) list_size--;
            pll_pkg::FN_CLEAR:  list_size = 0;
            default: ;
        endcase
    endtask

    task automatic send_random(int n, int insert_pct);
        int             r;
        int             pos;
        pll_pkg::t_func fn;
        logic [31:0]    din;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 2) fn = pll_pkg::FN_CLEAR;
            else if (r < insert_pct) fn = pll_pkg::FN_INSERT;
            else if (r < insert_pct + (100 - insert_pct) / 2) fn = pll_pkg::FN_DELETE;
            else fn = pll_pkg::FN_GET;
            if ($urandom_range(99) < 15) begin
                pos = $urandom_range(127);
            end else if (fn == pll_pkg::FN_INSERT) begin
                pos = $urandom_range(list_size + 1, 1);
            end else begin
                pos = (list_size == 0) ? 1 : $urandom_range(list_size, 1);
            end
            case ($urandom_range(9))
                0: din = '0;
                1: din = '1;
                default: din = $urandom();
            endcase
            send_request(fn, pos, din);
        end
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        list_size      = 0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(pll_pkg::FN_GET, 1, 32'h0);
        send_request(pll_pkg::FN_DELETE, 1, 32'h0);
        send_request(pll_pkg::FN_GET, 0, 32'h0);
        send_request(pll_pkg::FN_INSERT, 0, 32'h1111_1111);
        send_request(pll_pkg::FN_INSERT, 2, 32'h2222_2222);
        send_request(pll_pkg::FN_INSERT, 1, 32'hFFFF_FFFF);
        send_request(pll_pkg::FN_DELETE, 1, 32'h0);
        send_request(pll_pkg::FN_INSERT, 1, 32'h0000_0000);
        send_request(pll_pkg::FN_INSERT, 2, 32'hFFFF_FFFF);
        send_request(pll_pkg::FN_INSERT, 2, 32'hA5A5_5A5A);
        send_request(pll_pkg::FN_INSERT, 127, 32'h5A5A_A5A5);
        send_request(pll_pkg::FN_GET, 3, 32'h0);
        send_request(pll_pkg::FN_GET, 4, 32'h0);
        send_request(pll_pkg::FN_GET, 127, 32'h0);
        send_request(pll_pkg::FN_DELETE, 2, 32'h0);
        send_request(pll_pkg::FN_DELETE, 2, 32'h0);
        send_request(pll_pkg::FN_CLEAR, 0, 32'hFFFF_FFFF);
        send_request(pll_pkg::FN_GET, 1, 32'h0);
        while (list_size < CAPACITY) begin
            send_request(pll_pkg::FN_INSERT, list_size + 1, $urandom());
        end
        send_request(pll_pkg::FN_INSERT, 1, 32'hDEAD_BEEF);
        send_request(pll_pkg::FN_INSERT, 127, 32'hDEAD_BEEF);
        send_request(pll_pkg::FN_GET, 64, 32'h0);
        send_request(pll_pkg::FN_DELETE, 64, 32'h0);
        send_request(pll_pkg::FN_DELETE, 1, 32'h0);

        send_random(150, 60);
        send_idle_pct = 72;
        send_random(120, 45);
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        send_random(120, 80);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        send_random(120, 40);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 600;
        send_random(12, 50);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        send_random(60, 55);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[positional_linked_list_engine] OK");
        end else begin
            $display("[positional_linked_list_engine] ERROR");
        end
        $finish;
    end

endmodule

FILE: positional_linked_list_engine.f
sv/pll_pkg.sv
sv/pll_if.sv
sv/pll_ctrl.sv
sv/pll_dp.sv
sv/positional_linked_list_engine.sv
dv/pll_list_checker.sv
dv/tb_positional_linked_list_engine.sv
